[rtl/vblank_rate_monitor_core_macros.svh]
// Assertion shorthands used by the engine RTL file.
`ifndef VBLANK_RATE_MONITOR_CORE_MACROS_SVH
`define VBLANK_RATE_MONITOR_CORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define VRM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define VRM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/vrm_pkg.sv]
`default_nettype none

package vrm_pkg;

    localparam int unsigned SEQ_W      = 64;
    localparam int unsigned TIME_W     = 64;
    localparam int unsigned HOST_W     = 63;
    localparam int unsigned ADV_W      = 31;
    localparam int unsigned RATE_W     = 32;
    localparam int unsigned VERDICT_W  = 3;
    localparam int unsigned PPM_W      = 20;
    localparam int unsigned WIN_W      = 40;
    localparam int unsigned SLEW_W     = 30;
    localparam int unsigned STREAK_W   = 8;
    localparam int unsigned MUL_W      = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 40;

    localparam logic REQ_SETUP  = 1'b0;
    localparam logic REQ_VBLANK = 1'b1;

    localparam logic [VERDICT_W-1:0] V_NONE      = 3'd0;
    localparam logic [VERDICT_W-1:0] V_IN_BAND   = 3'd1;
    localparam logic [VERDICT_W-1:0] V_CANDIDATE = 3'd2;
    localparam logic [VERDICT_W-1:0] V_CONFIRMED = 3'd3;
    localparam logic [VERDICT_W-1:0] V_DISCARDED = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AGREE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLEW     = 3'd5;

    localparam logic [RATE_W-1:0] CLOCK_RATE_RST   = 32'd0;
    localparam logic [WIN_W-1:0]  WINDOW_RST       = 40'd5000000000;
    localparam logic [PPM_W-1:0]  MISMATCH_MIN_RST = 20'd300;
    localparam logic [PPM_W-1:0]  MISMATCH_MAX_RST = 20'd5000;
    localparam logic [PPM_W-1:0]  AGREE_RST        = 20'd100;
    localparam logic [SLEW_W-1:0] MAX_SLEW_RST     = 30'd1000000;

    localparam logic [MUL_W-1:0]    NS_PER_S    = 32'd1000000000;
    localparam logic [MUL_W-1:0]    PPM_SCALE   = 32'd1000000;
    localparam logic [ADV_W-1:0]    SEQ_ADV_MAX = 31'h7FFF_FFFF;
    localparam logic [RATE_W-1:0]   RATE_MAX    = 32'hFFFF_FFFF;
    localparam logic [STREAK_W-1:0] WARN_STREAK = 8'd3;
    localparam logic [STREAK_W-1:0] STREAK_MAX  = 8'hFF;

    typedef struct packed {
        logic              req_type;
        logic [SEQ_W-1:0]  vblank_seq;
        logic [TIME_W-1:0] vblank_time_ns;
        logic [HOST_W-1:0] host_time_ns;
    } vrm_req_t;

    typedef struct packed {
        logic [ADV_W-1:0]     seq_advance;
        logic [TIME_W-1:0]    corrected_time_ns;
        logic [VERDICT_W-1:0] verdict;
        logic [RATE_W-1:0]    measured_rate_q;
        logic                 streak_warning;
    } vrm_res_t;

    typedef struct packed {
        logic [RATE_W-1:0] clock_rate_q;
        logic [WIN_W-1:0]  window_ns;
        logic [PPM_W-1:0]  mismatch_min_ppm;
        logic [PPM_W-1:0]  mismatch_max_ppm;
        logic [PPM_W-1:0]  agree_ppm;
        logic [SLEW_W-1:0] max_slew_ns;
    } vrm_cfg_t;

endpackage

`default_nettype wire

[rtl/vrm_engine.sv]
`default_nettype none
`include "vblank_rate_monitor_core_macros.svh"

module vrm_engine
    import vrm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire vrm_cfg_t cfg,
    input  wire logic     start,
    input  wire vrm_req_t req,
    output logic          idle,
    output logic          res_valid,
    input  wire logic     res_ready,
    output vrm_res_t      res
);

    localparam int unsigned CNT_W = $clog2(RATE_W);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DRIFT  = 5'd1;
    localparam logic [4:0] S_NEG    = 5'd2;
    localparam logic [4:0] S_OFFS   = 5'd3;
    localparam logic [4:0] S_COR    = 5'd4;
    localparam logic [4:0] S_ADV    = 5'd5;
    localparam logic [4:0] S_DT     = 5'd6;
    localparam logic [4:0] S_WIN    = 5'd7;
    localparam logic [4:0] S_DSEQ   = 5'd8;
    localparam logic [4:0] S_MLO    = 5'd9;
    localparam logic [4:0] S_MHI    = 5'd10;
    localparam logic [4:0] S_MACC   = 5'd11;
    localparam logic [4:0] S_SAT    = 5'd12;
    localparam logic [4:0] S_DIV    = 5'd13;
    localparam logic [4:0] S_AD     = 5'd14;
    localparam logic [4:0] S_ABS    = 5'd15;
    localparam logic [4:0] S_DEVM   = 5'd16;
    localparam logic [4:0] S_LIMM   = 5'd17;
    localparam logic [4:0] S_CMPA   = 5'd18;
    localparam logic [4:0] S_MINM   = 5'd19;
    localparam logic [4:0] S_CMPMIN = 5'd20;
    localparam logic [4:0] S_EMIT   = 5'd21;

    logic [4:0]          state_reg;
    logic [4:0]          state_next;

    logic                running_reg;
    logic [SEQ_W-1:0]    last_seq_reg;
    logic [TIME_W-1:0]   offset_reg;
    logic [SEQ_W-1:0]    anchor_seq_reg;
    logic [TIME_W-1:0]   anchor_time_reg;
    logic                anchor_valid_reg;
    logic [RATE_W-1:0]   pending_reg;
    logic [STREAK_W-1:0] streak_reg;

    logic [SEQ_W-1:0]     seq_reg;
    logic [TIME_W-1:0]    vt_reg;
    logic [63:0]          tmp_reg;
    logic [63:0]          neg_reg;
    logic [TIME_W-1:0]    dt_reg;
    logic [61:0]          plo_reg;
    logic [63:0]          mul_reg;
    logic [63:0]          dev_reg;
    logic [63:0]          rem_reg;
    logic [RATE_W-1:0]    nsh_reg;
    logic [RATE_W-1:0]    q_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 neg_flag_reg;
    logic                 phase_reg;
    logic [ADV_W-1:0]     adv_reg;
    logic [TIME_W-1:0]    cor_reg;
    logic [VERDICT_W-1:0] verdict_reg;
    logic [RATE_W-1:0]    rate_reg;
    logic                 warn_reg;

    logic [64:0]         add_a;
    logic [64:0]         add_b;
    logic                add_sub;
    logic [65:0]         add_res;
    logic                add_borrow;
    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [63:0]         mul_p;

    logic [RATE_W-1:0]   ref_rate;
    logic [WIN_W-1:0]    win;
    logic [63:0]         p_mid;
    logic                rate_sat;
    logic [64:0]         div_shift;
    logic                div_ge;
    logic                div_last;
    logic [STREAK_W-1:0] streak_inc;
    logic                take_vblank;

    assign ref_rate    = phase_reg ? pending_reg : cfg.clock_rate_q;
    assign win         = (cfg.window_ns == '0) ? WIN_W'(1) : cfg.window_ns;
    assign p_mid       = {tmp_reg[39:0], plo_reg[31:8]};
    assign div_shift   = {rem_reg, nsh_reg[RATE_W-1]};
    assign div_last    = (cnt_reg == CNT_W'(RATE_W - 1));
    assign streak_inc  = (streak_reg == STREAK_MAX) ? streak_reg : streak_reg + 8'd1;
    assign take_vblank = start && (req.req_type == REQ_VBLANK) && running_reg
                         && (req.vblank_seq != last_seq_reg);

    // shared adder / subtractor
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                add_a = {2'b0, req.host_time_ns};
                add_b = {1'b0, req.vblank_time_ns};
            end
            S_DRIFT:
            begin
                add_a = {1'b0, tmp_reg};
                add_b = {1'b0, offset_reg};
            end
            S_NEG:
            begin
                add_b = {1'b0, tmp_reg};
            end
            S_OFFS:
            begin
                add_a = {1'b0, offset_reg};
                if (!tmp_reg[63] && (tmp_reg > {34'b0, cfg.max_slew_ns}))
                begin
                    add_b   = {35'b0, cfg.max_slew_ns};
                    add_sub = 1'b0;
                end
                else if (tmp_reg[63] && (neg_reg > {34'b0, cfg.max_slew_ns}))
                begin
                    add_b = {35'b0, cfg.max_slew_ns};
                end
                else
                begin
                    add_b   = {1'b0, tmp_reg};
                    add_sub = 1'b0;
                end
            end
            S_COR:
            begin
                add_a   = {1'b0, vt_reg};
                add_b   = {1'b0, offset_reg};
                add_sub = 1'b0;
            end
            S_ADV:
            begin
                add_a = {1'b0, seq_reg};
                add_b = {1'b0, last_seq_reg};
            end
            S_DT:
            begin
                add_a = {1'b0, vt_reg};
                add_b = {1'b0, anchor_time_reg};
            end
            S_WIN:
            begin
                add_a = {1'b0, dt_reg};
                add_b = {25'b0, win};
            end
            S_DSEQ:
            begin
                add_a = {1'b0, seq_reg};
                add_b = {1'b0, anchor_seq_reg};
            end
            S_MACC:
            begin
                add_a   = {1'b0, mul_reg};
                add_b   = {35'b0, plo_reg[61:32]};
                add_sub = 1'b0;
            end
            S_SAT:
            begin
                add_a = {1'b0, p_mid};
                add_b = {1'b0, dt_reg};
            end
            S_DIV:
            begin
                add_a = div_shift;
                add_b = {1'b0, dt_reg};
            end
            S_AD:
            begin
                add_a = {33'b0, rate_reg};
                add_b = {33'b0, ref_rate};
            end
            S_ABS:
            begin
                add_a = {33'b0, ref_rate};
                add_b = {33'b0, rate_reg};
            end
            S_CMPA:
            begin
                if (phase_reg)
                begin
                    add_a = {1'b0, dev_reg};
                    add_b = {1'b0, mul_reg};
                end
                else
                begin
                    add_a = {1'b0, mul_reg};
                    add_b = {1'b0, dev_reg};
                end
            end
            S_CMPMIN:
            begin
                add_a = {1'b0, mul_reg};
                add_b = {1'b0, dev_reg};
            end
            default:
            begin
            end
        endcase
    end

    assign add_res    = add_sub ? ({1'b0, add_a} - {1'b0, add_b})
                                : ({1'b0, add_a} + {1'b0, add_b});
    assign add_borrow = add_res[65];
    assign div_ge     = !add_borrow;
    assign rate_sat   = (|tmp_reg[61:40]) || !add_borrow;

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MLO:
            begin
                mul_a = tmp_reg[31:0];
                mul_b = NS_PER_S;
            end
            S_MHI:
            begin
                mul_a = tmp_reg[63:32];
                mul_b = NS_PER_S;
            end
            S_DEVM:
            begin
                mul_a = tmp_reg[31:0];
                mul_b = PPM_SCALE;
            end
            S_LIMM:
            begin
                mul_a = ref_rate;
                mul_b = phase_reg ? {12'b0, cfg.agree_ppm} : {12'b0, cfg.mismatch_max_ppm};
            end
            S_MINM:
            begin
                mul_a = cfg.clock_rate_q;
                mul_b = {12'b0, cfg.mismatch_min_ppm};
            end
            default:
            begin
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (take_vblank) state_next = S_DRIFT;
            S_DRIFT:  state_next = S_NEG;
            S_NEG:    state_next = S_OFFS;
            S_OFFS:   state_next = S_COR;
            S_COR:    state_next = S_ADV;
            S_ADV:    state_next = anchor_valid_reg ? S_DT : S_EMIT;
            S_DT:     state_next = S_WIN;
            S_WIN:    state_next = add_borrow ? S_EMIT : S_DSEQ;
            S_DSEQ:   state_next = S_MLO;
            S_MLO:    state_next = S_MHI;
            S_MHI:    state_next = S_MACC;
            S_MACC:   state_next = S_SAT;
            S_SAT:
            begin
                if (!rate_sat)
                    state_next = S_DIV;
                else
                    state_next = (cfg.clock_rate_q == '0) ? S_EMIT : S_AD;
            end
            S_DIV:
            begin
                if (div_last)
                    state_next = (cfg.clock_rate_q == '0) ? S_EMIT : S_AD;
            end
            S_AD:     state_next = S_ABS;
            S_ABS:    state_next = S_DEVM;
            S_DEVM:   state_next = S_LIMM;
            S_LIMM:   state_next = S_CMPA;
            S_CMPA:   state_next = (phase_reg || add_borrow) ? S_EMIT : S_MINM;
            S_MINM:   state_next = S_CMPMIN;
            S_CMPMIN: state_next = (add_borrow && (pending_reg != '0)) ? S_AD : S_EMIT;
            S_EMIT:   if (res_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            running_reg      <= 1'b0;
            last_seq_reg     <= '0;
            offset_reg       <= '0;
            anchor_seq_reg   <= '0;
            anchor_time_reg  <= '0;
            anchor_valid_reg <= 1'b0;
            pending_reg      <= '0;
            streak_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (start && (req.req_type == REQ_SETUP))
                    begin
                        running_reg      <= 1'b1;
                        last_seq_reg     <= req.vblank_seq;
                        offset_reg       <= add_res[63:0];
                        anchor_seq_reg   <= '0;
                        anchor_time_reg  <= '0;
                        anchor_valid_reg <= 1'b0;
                        pending_reg      <= '0;
                    end
                end
                S_OFFS:
                begin
                    offset_reg <= add_res[63:0];
                end
                S_ADV:
                begin
                    last_seq_reg <= seq_reg;
                    if (!anchor_valid_reg)
                    begin
                        anchor_seq_reg   <= seq_reg;
                        anchor_time_reg  <= vt_reg;
                        anchor_valid_reg <= 1'b1;
                    end
                end
                S_DSEQ:
                begin
                    anchor_seq_reg  <= seq_reg;
                    anchor_time_reg <= vt_reg;
                end
                S_CMPA:
                begin
                    if (!phase_reg && add_borrow)
                    begin
                        streak_reg  <= streak_inc;
                        pending_reg <= '0;
                    end
                    else if (phase_reg && add_borrow)
                    begin
                        streak_reg  <= '0;
                        running_reg <= 1'b0;
                    end
                    else if (phase_reg)
                    begin
                        pending_reg <= rate_reg;
                    end
                end
                S_CMPMIN:
                begin
                    if (!add_borrow)
                    begin
                        pending_reg <= '0;
                        streak_reg  <= '0;
                    end
                    else if (pending_reg == '0)
                    begin
                        pending_reg <= rate_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (take_vblank)
                begin
                    seq_reg     <= req.vblank_seq;
                    vt_reg      <= req.vblank_time_ns;
                    tmp_reg     <= add_res[63:0];
                    verdict_reg <= V_NONE;
                    rate_reg    <= '0;
                    warn_reg    <= 1'b0;
                end
            end
            S_DRIFT: tmp_reg <= add_res[63:0];
            S_NEG:   neg_reg <= add_res[63:0];
            S_COR:   cor_reg <= add_res[63:0];
            S_ADV:   adv_reg <= (|add_res[63:ADV_W]) ? SEQ_ADV_MAX : add_res[ADV_W-1:0];
            S_DT:    dt_reg  <= add_res[63:0];
            S_DSEQ:  tmp_reg <= add_res[63:0];
            S_MLO:   mul_reg <= mul_p;
            S_MHI:
            begin
                plo_reg <= mul_reg[61:0];
                mul_reg <= mul_p;
            end
            S_MACC:  tmp_reg <= add_res[63:0];
            S_SAT:
            begin
                rem_reg   <= p_mid;
                nsh_reg   <= {plo_reg[7:0], 24'b0};
                q_reg     <= '0;
                cnt_reg   <= '0;
                phase_reg <= 1'b0;
                if (rate_sat)
                    rate_reg <= RATE_MAX;
            end
            S_DIV:
            begin
                rem_reg <= div_ge ? add_res[63:0] : div_shift[63:0];
                nsh_reg <= {nsh_reg[RATE_W-2:0], 1'b0};
                q_reg   <= {q_reg[RATE_W-2:0], div_ge};
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (div_last)
                    rate_reg <= {q_reg[RATE_W-2:0], div_ge};
            end
            S_AD:
            begin
                tmp_reg      <= add_res[63:0];
                neg_flag_reg <= add_borrow;
            end
            S_ABS:
            begin
                if (neg_flag_reg)
                    tmp_reg <= add_res[63:0];
            end
            S_DEVM:  mul_reg <= mul_p;
            S_LIMM:
            begin
                dev_reg <= mul_reg;
                mul_reg <= mul_p;
            end
            S_CMPA:
            begin
                if (!phase_reg && add_borrow)
                begin
                    verdict_reg <= V_DISCARDED;
                    warn_reg    <= (streak_inc == WARN_STREAK);
                end
                else if (phase_reg)
                begin
                    verdict_reg <= add_borrow ? V_CONFIRMED : V_CANDIDATE;
                end
            end
            S_MINM:  mul_reg <= mul_p;
            S_CMPMIN:
            begin
                if (!add_borrow)
                    verdict_reg <= V_IN_BAND;
                else if (pending_reg == '0)
                    verdict_reg <= V_CANDIDATE;
                else
                    phase_reg <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT);

    always_comb
    begin
        res.seq_advance       = adv_reg;
        res.corrected_time_ns = cor_reg;
        res.verdict           = verdict_reg;
        res.measured_rate_q   = rate_reg;
        res.streak_warning    = warn_reg;
    end

    `VRM_ASSERT_IMP(a_confirm_stops, clk, rst_n, res_valid && (res.verdict == V_CONFIRMED), !running_reg, "confirmed window left the monitor running")
    `VRM_ASSERT_IMP(a_warn_on_third, clk, rst_n, res_valid && res.streak_warning, (res.verdict == V_DISCARDED) && (streak_reg == WARN_STREAK), "streak warning without third discard")
    `VRM_ASSERT_IMP(a_rem_below_dt, clk, rst_n, state_reg == S_DIV, rem_reg < dt_reg, "divider remainder not below window time")
    `VRM_ASSERT_NXT(a_stopped_drops, clk, rst_n, start && !running_reg, state_reg == S_IDLE, "request worked on while stopped")

endmodule

`default_nettype wire

[rtl/vblank_rate_monitor_core.sv]
// Vblank rate monitor.
// Input channel in_valid / in_stall carries in_req: a setup request (req_type 0)
// re-anchors the monitor, a vblank request (req_type 1) carries a sample.
// Output channel out_valid / out_stall carries out_res: sequence advance,
// corrected timestamp, window verdict, measured rate and streak warning.
// A setup request, a vblank while stopped and a repeated sequence number give
// no result. The first vblank after a setup skips the window steps, a later
// one that closes no window stops after the window check, and one that closes
// a measuring window can also run the 32 steps of the shared restoring divider
// and the band checks on the shared multiplier.
// One request is worked on at a time; in_stall is high from acceptance until
// the result has moved into the output register.
// A result waiting under out_stall does not block the next request, but a
// second result waits inside until the output register frees.
// Reset empties the output register, stops the monitor and loads the default
// configuration. Registers are written through cfg_we / cfg_index / cfg_data
// by the user only while the monitor is idle; the block does not enforce it.
`default_nettype none

module vblank_rate_monitor_core
    import vrm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire vrm_req_t              in_req,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output vrm_res_t                   out_res,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    vrm_cfg_t cfg_reg;
    logic     out_valid_reg;
    vrm_res_t out_res_reg;

    logic     eng_idle;
    logic     eng_res_valid;
    vrm_res_t eng_res;
    logic     out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clock_rate_q     <= CLOCK_RATE_RST;
            cfg_reg.window_ns        <= WINDOW_RST;
            cfg_reg.mismatch_min_ppm <= MISMATCH_MIN_RST;
            cfg_reg.mismatch_max_ppm <= MISMATCH_MAX_RST;
            cfg_reg.agree_ppm        <= AGREE_RST;
            cfg_reg.max_slew_ns      <= MAX_SLEW_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLOCK_RATE:   cfg_reg.clock_rate_q     <= cfg_data[RATE_W-1:0];
                CFG_WINDOW:       cfg_reg.window_ns        <= cfg_data[WIN_W-1:0];
                CFG_MISMATCH_MIN: cfg_reg.mismatch_min_ppm <= cfg_data[PPM_W-1:0];
                CFG_MISMATCH_MAX: cfg_reg.mismatch_max_ppm <= cfg_data[PPM_W-1:0];
                CFG_AGREE:        cfg_reg.agree_ppm        <= cfg_data[PPM_W-1:0];
                CFG_MAX_SLEW:     cfg_reg.max_slew_ns      <= cfg_data[SLEW_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall = !eng_idle;
    assign out_free = !out_valid_reg || !out_stall;

    vrm_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .start     (in_valid && eng_idle),
        .req       (in_req),
        .idle      (eng_idle),
        .res_valid (eng_res_valid),
        .res_ready (out_free),
        .res       (eng_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (eng_res_valid && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // hold the result while stalled
    always_ff @(posedge clk)
    begin
        if (eng_res_valid && out_free)
            out_res_reg <= eng_res;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

`default_nettype wire

[dv/vblank_rate_monitor_core_test.sv]
`timescale 1ns / 100ps

module vblank_rate_monitor_core_test
    import vrm_pkg::*;
();

    localparam logic [127:0] NS_Q24 = 128'd1000000000 << 24;
    localparam logic [31:0] RATE_60HZ = 32'd1006632960;

    class rate_scoreboard;
        logic [31:0] ref_rate;
        logic [39:0] window_len;
        logic [19:0] band_lo_ppm;
        logic [19:0] band_hi_ppm;
        logic [19:0] agree_tol_ppm;
        logic [29:0] slew_limit;
        logic active;
        logic win_open;
        logic [63:0] prev_seq;
        logic [63:0] host_offset;
        logic [63:0] win_start_seq;
        logic [63:0] win_start_time;
        logic [63:0] held_rate;
        logic [7:0] discard_run;
        vrm_res_t due_reports[$];
        int mismatches;
        int worked;

        function new();
            ref_rate = CLOCK_RATE_RST;
            window_len = WINDOW_RST;
            band_lo_ppm = MISMATCH_MIN_RST;
            band_hi_ppm = MISMATCH_MAX_RST;
            agree_tol_ppm = AGREE_RST;
            slew_limit = MAX_SLEW_RST;
            active = 1'b0;
            win_open = 1'b0;
            prev_seq = '0;
            host_offset = '0;
            win_start_seq = '0;
            win_start_time = '0;
            held_rate = '0;
            discard_run = '0;
            mismatches = 0;
            worked = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_CLOCK_RATE:   ref_rate = val[RATE_W-1:0];
                CFG_WINDOW:       window_len = val[WIN_W-1:0];
                CFG_MISMATCH_MIN: band_lo_ppm = val[PPM_W-1:0];
                CFG_MISMATCH_MAX: band_hi_ppm = val[PPM_W-1:0];
                CFG_AGREE:        agree_tol_ppm = val[PPM_W-1:0];
                CFG_MAX_SLEW:     slew_limit = val[SLEW_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(vrm_req_t r);
            logic [63:0] host;
            logic [63:0] step;
            logic [63:0] neg;
            logic [63:0] adv;
            logic [63:0] span;
            logic [63:0] dt;
            logic [63:0] c;
            logic [63:0] dev;
            logic [63:0] rate;
            logic [127:0] quo;
            vrm_res_t rep;
            host = {1'b0, r.host_time_ns};
            if (r.req_type == REQ_SETUP) begin
                active = 1'b1;
                prev_seq = r.vblank_seq;
                host_offset = host - r.vblank_time_ns;
                win_start_seq = '0;
                win_start_time = '0;
                win_open = 1'b0;
                held_rate = '0;
                worked++;
                return;
            end
            if (!active || r.vblank_seq == prev_seq)
                return;

            // follow the observed offset, limited to the slew per vblank
            step = host - r.vblank_time_ns - host_offset;
            neg = 64'd0 - step;
            if (!step[63]) begin
                if (step > 64'(slew_limit))
                    step = 64'(slew_limit);
            end
            else if (neg > 64'(slew_limit)) begin
                step = 64'd0 - 64'(slew_limit);
            end
            host_offset = host_offset + step;

            adv = r.vblank_seq - prev_seq;
            if (adv > 64'(SEQ_ADV_MAX))
                adv = 64'(SEQ_ADV_MAX);
            prev_seq = r.vblank_seq;

            rep = '0;
            rep.seq_advance = adv[ADV_W-1:0];
            rep.corrected_time_ns = r.vblank_time_ns + host_offset;
            rep.verdict = V_NONE;

            if (!win_open) begin
                win_start_seq = r.vblank_seq;
                win_start_time = r.vblank_time_ns;
                win_open = 1'b1;
            end
            else begin
                span = (window_len == 0) ? 64'd1 : 64'(window_len);
                dt = r.vblank_time_ns - win_start_time;
                if (dt >= span) begin
                    quo = ({64'd0, r.vblank_seq - win_start_seq} * NS_Q24) / {64'd0, dt};
                    rate = (quo > 128'(RATE_MAX)) ? 64'(RATE_MAX) : quo[63:0];
                    rep.measured_rate_q = rate[RATE_W-1:0];
                    win_start_seq = r.vblank_seq;
                    win_start_time = r.vblank_time_ns;
                    if (ref_rate != 0) begin
                        c = 64'(ref_rate);
                        dev = ((rate > c) ? rate - c : c - rate) * 64'd1000000;
                        if (dev > 64'(band_hi_ppm) * c) begin
                            if (discard_run != STREAK_MAX)
                                discard_run++;
                            rep.streak_warning = (discard_run == WARN_STREAK);
                            held_rate = '0;
                            rep.verdict = V_DISCARDED;
                        end
                        else if (dev > 64'(band_lo_ppm) * c) begin
                            if (held_rate != 0 &&
                                ((rate > held_rate) ? rate - held_rate : held_rate - rate)
                                    * 64'd1000000 < 64'(agree_tol_ppm) * held_rate) begin
                                discard_run = '0;
                                active = 1'b0;
                                rep.verdict = V_CONFIRMED;
                            end
                            else begin
                                held_rate = rate;
                                rep.verdict = V_CANDIDATE;
                            end
                        end
                        else begin
                            held_rate = '0;
                            discard_run = '0;
                            rep.verdict = V_IN_BAND;
                        end
                    end
                end
            end
            due_reports.push_back(rep);
            worked++;
        endfunction

        function void check_report(vrm_res_t got);
            vrm_res_t want;
            if (due_reports.size() == 0) begin
                $error("report arrived with none due: %p", got);
                mismatches++;
                return;
            end
            want = due_reports.pop_front();
            if (got.seq_advance !== want.seq_advance) begin
                $error("seq_advance: expected %0d, got %0d", want.seq_advance, got.seq_advance);
                mismatches++;
            end
            if (got.corrected_time_ns !== want.corrected_time_ns) begin
                $error("corrected_time_ns: expected %0d, got %0d",
                       want.corrected_time_ns, got.corrected_time_ns);
                mismatches++;
            end
            if (got.verdict !== want.verdict) begin
                $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                mismatches++;
            end
            if (got.measured_rate_q !== want.measured_rate_q) begin
                $error("measured_rate_q: expected %0d, got %0d",
                       want.measured_rate_q, got.measured_rate_q);
                mismatches++;
            end
            if (got.streak_warning !== want.streak_warning) begin
                $error("streak_warning: expected %0d, got %0d",
                       want.streak_warning, got.streak_warning);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    vrm_req_t in_req = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    vrm_res_t out_res;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit pressure_go = 1'b0;
    logic hold_off = 1'b0;

    rate_scoreboard sb = new();

    vblank_rate_monitor_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_req(in_req),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_res(out_res),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_report(out_res);
        out_stall <= hold_off || ($urandom_range(99) < rx_idle_pct);
    end

    // hold off the receiver long enough to back the block up
    initial
    begin
        wait (pressure_go);
        repeat (600) @(posedge clk) hold_off <= 1'b1;
        @(posedge clk) hold_off <= 1'b0;
    end

    initial
    begin
        #15_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] rand_rate();
        return (32'($urandom_range(24, 239)) << 24) | 32'($urandom_range(0, 32'hFF_FFFF));
    endfunction

    function automatic logic [63:0] period_ns(logic [31:0] c, int ppm);
        logic [63:0] target;
        target = (64'(c) * 64'(1000000 + ppm)) / 64'd1000000;
        if (target == 0)
            target = 64'd1;
        return 64'(NS_Q24) / target;
    endfunction

    function automatic logic [39:0] window_for(logic [31:0] c, int k);
        logic [63:0] p;
        logic [63:0] w;
        p = period_ns(c, 0);
        w = p * 64'(k) - p / 2;
        return (w > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : w[39:0];
    endfunction

    function automatic vrm_req_t make_request(logic kind, logic [63:0] seq, logic [63:0] vt,
                                              logic [63:0] host);
        vrm_req_t r;
        r.req_type = kind;
        r.vblank_seq = seq;
        r.vblank_time_ns = vt;
        r.host_time_ns = host[HOST_W-1:0];
        return r;
    endfunction

    task automatic offer(vrm_req_t r);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req <= r;
        do @(posedge clk); while (in_stall);
        sb.note_request(r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.due_reports.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
    endtask

    task automatic configure(logic [31:0] c, logic [39:0] win, logic [19:0] lo,
                             logic [19:0] hi, logic [19:0] agree, logic [29:0] slew);
        write_reg(CFG_CLOCK_RATE, 40'(c));
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_MISMATCH_MIN, 40'(lo));
        write_reg(CFG_MISMATCH_MAX, 40'(hi));
        write_reg(CFG_AGREE, 40'(agree));
        write_reg(CFG_MAX_SLEW, 40'(slew));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // a setup, maybe after stray requests, then vblanks some ppm off the clock
    task automatic run_burst();
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] p;
        logic [63:0] offs;
        logic [63:0] wander;
        logic [63:0] d;
        logic [31:0] c;
        logic [19:0] lo;
        logic [19:0] hi;
        int mag;
        int ppm;
        int jit;
        int n;
        c = (sb.ref_rate != 0) ? sb.ref_rate : RATE_60HZ;
        lo = sb.band_lo_ppm;
        hi = sb.band_hi_ppm;
        case ($urandom_range(5))
            0: mag = $urandom_range(0, lo);
            1, 2: mag = (hi > lo) ? $urandom_range(lo + 1, hi) : $urandom_range(lo, lo + 2000);
            3: mag = hi + $urandom_range(1, 20000);
            4: mag = $urandom_range(0, 2000);
            default: mag = $urandom_range(0, 200000);
        endcase
        if (mag > 900000)
            mag = 900000;
        ppm = $urandom_range(1) ? mag : -mag;
        p = period_ns(c, ppm);
        s = rand64();
        t = rand64();
        offs = rand64();
        wander = '0;
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(1, 3))
                offer(make_request(1'($urandom_range(1)), rand64(), rand64(), rand64()));
        offer(make_request(REQ_SETUP, s, t, t + offs));
        n = $urandom_range(3, 16);
        repeat (n) begin
            d = 64'd1;
            case ($urandom_range(23))
                0: d = 64'd0;
                1: d = 64'($urandom_range(2, 6));
                2: s = rand64();
                3: t = rand64();
                4: s = s - 64'($urandom_range(1, 1000));
                default: ;
            endcase
            s = s + d;
            jit = int'($urandom_range(0, 6)) - 3;
            t = t + p * d + 64'(jit);
            case ($urandom_range(15))
                0: wander = rand64();
                1: wander = wander + 64'(int'($urandom_range(0, 2000000000)) - 1000000000);
                default: wander = wander + 64'(int'($urandom_range(0, 4000)) - 2000);
            endcase
            offer(make_request(REQ_VBLANK, s, t, t + offs + wander));
        end
    endtask

    initial
    begin
        int good_run[5] = '{0, 0, 1000, 1000, 0};
        int bad_run[5] = '{0, 20000, 20000, 20000, 0};
        int odd_run[3] = '{0, 1000, 100};
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] offs;
        logic [31:0] c;
        int ph;
        int k;
        int target;
        int i;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // checks off, zero window, no slew: stopped, repeat, wrap and saturation
        configure(32'd0, 40'd0, 20'd300, 20'd5000, 20'd100, 30'd0);
        offer(make_request(REQ_VBLANK, 64'd5, 64'd0, 64'd0));
        offer(make_request(REQ_SETUP, 64'd0, 64'd0, 64'd0));
        offer(make_request(REQ_VBLANK, 64'd0, 64'd10, 64'd0));
        offer(make_request(REQ_VBLANK, 64'd1, '1, 64'h7FFF_FFFF_FFFF_FFFF));
        offer(make_request(REQ_VBLANK, '1, 64'd0, 64'd0));
        offer(make_request(REQ_VBLANK, 64'd2, 64'd100, 64'd50));
        drain();

        // in band, candidate, confirm and stop, then a streak of discards
        configure(RATE_60HZ, 40'd1000, 20'd300, 20'd5000, 20'd100, 30'd1000000000);
        offs = 64'h4000_0000_0000_0000;
        t = 64'd1000;
        s = 64'd100;
        offer(make_request(REQ_SETUP, s, t, t + offs));
        foreach (good_run[j]) begin
            s = s + 1;
            t = t + period_ns(RATE_60HZ, good_run[j]);
            offer(make_request(REQ_VBLANK, s, t, t + offs));
        end
        s = 64'd200;
        offer(make_request(REQ_SETUP, s, t, t + offs));
        foreach (bad_run[j]) begin
            s = s + 1;
            t = t + period_ns(RATE_60HZ, bad_run[j]);
            offer(make_request(REQ_VBLANK, s, t, t + offs));
        end
        drain();

        // minimum above maximum
        configure(RATE_60HZ, 40'd1000, 20'd5000, 20'd300, 20'd100, 30'd1000000);
        offer(make_request(REQ_SETUP, s, t, t + offs));
        foreach (odd_run[j]) begin
            s = s + 1;
            t = t + period_ns(RATE_60HZ, odd_run[j]);
            offer(make_request(REQ_VBLANK, s, t, t + offs));
        end

        for (ph = 0; ph < 9; ph++) begin
            drain();
            tx_idle_pct = (ph < 3) ? 32 : (ph < 6) ? 86 : 0;
            rx_idle_pct = (ph < 3) ? 86 : (ph < 6) ? 32 : 0;
            k = $urandom_range(1, 3);
            case (ph)
                0: configure(RATE_60HZ, window_for(RATE_60HZ, k), 20'd300, 20'd5000, 20'd100,
                             30'd1000000);
                1: configure(32'hFFFF_FFFF, window_for(32'hFFFF_FFFF, k), 20'd0, 20'd1000000,
                             20'd1000000, 30'd0);
                2: configure(32'd0, window_for(RATE_60HZ, k), 20'($urandom_range(0, 1000000)),
                             20'($urandom_range(0, 1000000)), 20'($urandom_range(0, 1000000)),
                             30'($urandom_range(0, 1000000000)));
                3: begin
                    c = rand_rate();
                    configure(c, window_for(c, k), 20'd1000000, 20'd1000000, 20'd0,
                              30'd1000000000);
                end
                4: configure(RATE_60HZ, window_for(RATE_60HZ, k), 20'd0, 20'd0, 20'd0,
                             30'($urandom_range(0, 1000000)));
                5: configure(RATE_60HZ, window_for(RATE_60HZ, k), 20'd5000, 20'd300, 20'd100,
                             30'd1000000);
                6: configure(rand_rate(), 40'hFF_FFFF_FFFF, 20'd300, 20'd5000, 20'd100,
                             30'd1000000);
                7: configure(rand_rate(), 40'd0, 20'd300, 20'd5000, 20'd100, 30'd1000000);
                default: begin
                    c = $urandom;
                    configure(c, window_for(c, k), 20'($urandom_range(0, 1000000)),
                              20'($urandom_range(0, 1000000)), 20'($urandom_range(0, 1000000)),
                              30'($urandom_range(0, 1000000000)));
                end
            endcase
            if (ph == 6)
                pressure_go = 1'b1;
            target = sb.worked + 200;
            while (sb.worked < target)
                run_burst();
        end

        in_valid <= 1'b0;
        for (i = 0; i < 5000 && sb.due_reports.size() != 0; i++)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (sb.due_reports.size() != 0) begin
            $error("%0d reports never arrived", sb.due_reports.size());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
